// ===== sv/crcfr_pkg.sv =====
// package: shared types, codes and the crc byte update for the frame receiver
`default_nettype none
package crcfr_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_START_MARKER = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_END_MARKER   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DATA_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_END_TIMEOUT  = 3'd4;

  // configuration reset values
  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST   = 8'h55;
  localparam logic [15:0] MAX_LENGTH_RST   = 16'd256;
  localparam logic [15:0] DATA_TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] END_TIMEOUT_RST  = 16'd100;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // input item types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT = 3'd1;
  localparam logic [2:0] ERR_OVERLEN = 3'd2;
  localparam logic [2:0] ERR_CRC     = 3'd3;
  localparam logic [2:0] ERR_NOEND   = 3'd4;
  localparam logic [2:0] ERR_EMPTY   = 3'd5;

  // frame phase, one-hot
  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_LEN_HI = 7'b0000010,
    PH_LEN_LO = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_CRC_HI = 7'b0010000,
    PH_CRC_LO = 7'b0100000,
    PH_END    = 7'b1000000
  } phase_e;

  // configuration register set
  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] max_length;
    logic [15:0] data_timeout_ticks;
    logic [15:0] end_timeout_ticks;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [2:0]  error_code;
    logic [15:0] frame_length;
    logic [7:0]  message_type;
  } res_t;

  // crc update over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/crcfr_if.sv =====
// interfaces: input item, result item and configuration write channels
`default_nettype none
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [2:0]  error_code;
  logic [15:0] frame_length;
  logic [7:0]  message_type;
  modport source (output valid, output result_kind, output payload_byte,
                  output byte_index, output error_code, output frame_length,
                  output message_type, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input byte_index, input error_code, input frame_length,
                input message_type, output ready);
endinterface

interface crcfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/crcfr_cfg_regs.sv =====
// configuration register file
`default_nettype none
module crcfr_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  crcfr_cfg_if.sink         cfg_i,
  output crcfr_pkg::cfg_t   cfg_o
);

  crcfr_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en = cfg_i.valid & cfg_i.ready;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_i.index)
        crcfr_pkg::REG_START_MARKER: cfg_d.start_marker       = cfg_i.data[7:0];
        crcfr_pkg::REG_END_MARKER:   cfg_d.end_marker         = cfg_i.data[7:0];
        crcfr_pkg::REG_MAX_LENGTH:   cfg_d.max_length         = cfg_i.data;
        crcfr_pkg::REG_DATA_TIMEOUT: cfg_d.data_timeout_ticks = cfg_i.data;
        crcfr_pkg::REG_END_TIMEOUT:  cfg_d.end_timeout_ticks  = cfg_i.data;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker       <= crcfr_pkg::START_MARKER_RST;
      cfg_q.end_marker         <= crcfr_pkg::END_MARKER_RST;
      cfg_q.max_length         <= crcfr_pkg::MAX_LENGTH_RST;
      cfg_q.data_timeout_ticks <= crcfr_pkg::DATA_TIMEOUT_RST;
      cfg_q.end_timeout_ticks  <= crcfr_pkg::END_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/crcfr_fsm.sv =====
// frame state machine: marker hunt, length, payload crc, crc check, end wait
`default_nettype none
module crcfr_fsm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic            req_type_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire crcfr_pkg::cfg_t cfg_i,
  output logic                 res_valid_o,
  output crcfr_pkg::res_t      res_o
);

  crcfr_pkg::phase_e phase_q, phase_d;
  logic [15:0] decl_len_q, decl_len_d;
  logic [15:0] rcv_cnt_q, rcv_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  type_q, type_d;

  logic [15:0] tick_inc;
  logic [15:0] tick_limit;
  logic [15:0] len_new;
  logic [15:0] rcv_inc;
  logic [1:0]  kind;
  logic [7:0]  pbyte;
  logic [15:0] idx;
  logic [2:0]  err;

  assign tick_inc   = (tick_q == crcfr_pkg::TICK_MAX) ? tick_q : tick_q + 16'd1;
  assign tick_limit = (phase_q == crcfr_pkg::PH_DATA) ? cfg_i.data_timeout_ticks
                                                       : cfg_i.end_timeout_ticks;
  assign len_new    = {len_hi_q, rx_byte_i};
  assign rcv_inc    = rcv_cnt_q + 16'd1;

  // next state and result for one item
  always_comb begin
    phase_d     = phase_q;
    decl_len_d  = decl_len_q;
    rcv_cnt_d   = rcv_cnt_q;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    len_hi_d    = len_hi_q;
    tick_d      = tick_q;
    type_d      = type_q;
    res_valid_o = 1'b0;
    kind        = crcfr_pkg::KIND_DATA;
    pbyte       = 8'h00;
    idx         = 16'h0000;
    err         = crcfr_pkg::ERR_NONE;
    if (accept_i) begin
      if (req_type_i == crcfr_pkg::REQ_TICK) begin
        // timeouts only run in payload and end wait
        if (phase_q == crcfr_pkg::PH_DATA || phase_q == crcfr_pkg::PH_END) begin
          tick_d = tick_inc;
          if (tick_inc >= tick_limit) begin
            res_valid_o = 1'b1;
            kind        = crcfr_pkg::KIND_ERR;
            err         = (phase_q == crcfr_pkg::PH_DATA) ? crcfr_pkg::ERR_TIMEOUT
                                                          : crcfr_pkg::ERR_NOEND;
            idx         = rcv_cnt_q;
            phase_d     = crcfr_pkg::PH_HUNT;
          end
        end
      end else begin
        unique case (phase_q)
          crcfr_pkg::PH_HUNT: begin
            if (rx_byte_i == cfg_i.start_marker) begin
              decl_len_d = 16'h0000;
              rcv_cnt_d  = 16'h0000;
              type_d     = 8'h00;
              phase_d    = crcfr_pkg::PH_LEN_HI;
            end
          end
          crcfr_pkg::PH_LEN_HI: begin
            len_hi_d = rx_byte_i;
            phase_d  = crcfr_pkg::PH_LEN_LO;
          end
          crcfr_pkg::PH_LEN_LO: begin
            decl_len_d = len_new;
            rcv_cnt_d  = 16'h0000;
            crc_d      = crcfr_pkg::CRC_INIT;
            tick_d     = 16'h0000;
            if (len_new > cfg_i.max_length) begin
              res_valid_o = 1'b1;
              kind        = crcfr_pkg::KIND_ERR;
              err         = crcfr_pkg::ERR_OVERLEN;
              phase_d     = crcfr_pkg::PH_HUNT;
            end else if (len_new == 16'h0000) begin
              phase_d = crcfr_pkg::PH_CRC_HI;
            end else begin
              phase_d = crcfr_pkg::PH_DATA;
            end
          end
          crcfr_pkg::PH_DATA: begin
            if (rcv_cnt_q == 16'h0000) begin
              type_d = rx_byte_i;
            end
            crc_d       = crcfr_pkg::crc_byte(crc_q, rx_byte_i);
            rcv_cnt_d   = rcv_inc;
            if (rcv_inc >= decl_len_q) begin
              phase_d = crcfr_pkg::PH_CRC_HI;
            end
            res_valid_o = 1'b1;
            kind        = crcfr_pkg::KIND_DATA;
            pbyte       = rx_byte_i;
            idx         = rcv_cnt_q;
          end
          crcfr_pkg::PH_CRC_HI: begin
            crc_hi_d = rx_byte_i;
            phase_d  = crcfr_pkg::PH_CRC_LO;
          end
          crcfr_pkg::PH_CRC_LO: begin
            if ({crc_hi_q, rx_byte_i} != crc_q) begin
              res_valid_o = 1'b1;
              kind        = crcfr_pkg::KIND_ERR;
              err         = crcfr_pkg::ERR_CRC;
              idx         = rcv_cnt_q;
              phase_d     = crcfr_pkg::PH_HUNT;
            end else begin
              tick_d  = 16'h0000;
              phase_d = crcfr_pkg::PH_END;
            end
          end
          crcfr_pkg::PH_END: begin
            // other bytes are skipped while waiting for the end marker
            if (rx_byte_i == cfg_i.end_marker) begin
              res_valid_o = 1'b1;
              idx         = rcv_cnt_q;
              phase_d     = crcfr_pkg::PH_HUNT;
              if (decl_len_q == 16'h0000) begin
                kind = crcfr_pkg::KIND_ERR;
                err  = crcfr_pkg::ERR_EMPTY;
              end else begin
                kind = crcfr_pkg::KIND_OK;
                err  = crcfr_pkg::ERR_NONE;
              end
            end
          end
          default: phase_d = crcfr_pkg::PH_HUNT;
        endcase
      end
    end
  end

  // result fields, status carries the updated length and type
  always_comb begin
    res_o.result_kind  = kind;
    res_o.payload_byte = pbyte;
    res_o.byte_index   = idx;
    res_o.error_code   = err;
    res_o.frame_length = decl_len_d;
    res_o.message_type = type_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= crcfr_pkg::PH_HUNT;
      decl_len_q <= 16'h0000;
      rcv_cnt_q  <= 16'h0000;
      crc_q      <= crcfr_pkg::CRC_INIT;
      crc_hi_q   <= 8'h00;
      len_hi_q   <= 8'h00;
      tick_q     <= 16'h0000;
      type_q     <= 8'h00;
    end else begin
      phase_q    <= phase_d;
      decl_len_q <= decl_len_d;
      rcv_cnt_q  <= rcv_cnt_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
      len_hi_q   <= len_hi_d;
      tick_q     <= tick_d;
      type_q     <= type_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/crcfr_out_reg.sv =====
// result register toward the output channel
`default_nettype none
module crcfr_out_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire crcfr_pkg::res_t res_i,
  output logic                 free_o,
  crcfr_out_if.source          out_o
);

  logic            valid_q, valid_d;
  crcfr_pkg::res_t res_q;

  // register may take a new item when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.result_kind  = res_q.result_kind;
  assign out_o.payload_byte = res_q.payload_byte;
  assign out_o.byte_index   = res_q.byte_index;
  assign out_o.error_code   = res_q.error_code;
  assign out_o.frame_length = res_q.frame_length;
  assign out_o.message_type = res_q.message_type;

endmodule
`default_nettype wire

// ===== sv/crc16_length_framed_receiver_top.sv =====
// top level: length-framed receiver with crc-16 check
// a result item is registered and becomes valid in the cycle after the input item that causes it
// throughput: one item per cycle unless the output stalls, set by the single state update
//   per item and the one-deep result register, which refills in the cycle it is drained
// reset: asynchronous, active low; state returns to marker hunt, config to defaults
`default_nettype none
module crc16_length_framed_receiver_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  crcfr_in_if.sink    in_i,
  crcfr_cfg_if.sink   cfg_i,
  crcfr_out_if.source out_o
);

  crcfr_pkg::cfg_t cfg;
  crcfr_pkg::res_t res;
  logic            res_valid;
  logic            free;
  logic            accept;

  // item handshake
  assign in_i.ready = free;
  assign accept     = in_i.valid & free;

  crcfr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  crcfr_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (in_i.req_type),
    .rx_byte_i   (in_i.rx_byte),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crcfr_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
